// ----- design/cpc_pkg.sv -----
// Shared definitions for the contrast pixel counter: field widths,
// register indexes, register reset values, default buffer sizes and the pixel contrast test.
// No dependencies.
package cpc_pkg;

    localparam int PIXEL_W     = 8;
    localparam int COUNT_W     = 19;
    localparam int CFG_W       = 10;
    localparam int CFG_INDEX_W = 2;
    localparam int THRESH_W    = 8;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 24;

    localparam int DEFAULT_MAX_WIDTH  = 512;
    localparam int DEFAULT_MAX_HEIGHT = 512;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CONTRAST_THRESHOLD = 2'd2;

    localparam logic [CFG_W-1:0]    RESET_IMAGE_WIDTH        = 10'd320;
    localparam logic [CFG_W-1:0]    RESET_IMAGE_HEIGHT       = 10'd200;
    localparam logic [THRESH_W-1:0] RESET_CONTRAST_THRESHOLD = 8'd128;

    // Absolute difference of two pixels, compared against the threshold.
    function automatic logic differs(input logic [PIXEL_W-1:0] a,
                                     input logic [PIXEL_W-1:0] b,
                                     input logic [THRESH_W-1:0] thr);
        logic [PIXEL_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d > thr;
    endfunction

endpackage

// ----- design/cpc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Read-first on a same-address collision. No dependencies.
module cpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/contrast_pixel_counter_top.sv -----
// Contrast pixel counter: one pixel per cycle, two stages (line-buffer read, then update).
// The count is registered onto m_tdata once the frame's last pixel leaves the update stage.
// Throughput: one pixel per clock, set by the read-modify-write of the two line buffers;
// the input stalls only while a frame's last pixel waits for the previous count to leave.
// Reset (synchronous, aresetn low): clears position, count, pipeline and output valid, and
// loads the register defaults; the line buffers are not cleared and need no clearing pass.
// Depends on cpc_pkg and cpc_ram.
module contrast_pixel_counter_top #(
    parameter int MAX_WIDTH  = cpc_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = cpc_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [cpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cpc_pkg::CFG_W-1:0]         cfg_wdata,
    // pixel stream in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cpc_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] pixel
    // count stream out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cpc_pkg::M_TDATA_W-1:0]     m_tdata    // [18:0] contrast_count, rest zero
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int GW_W  = ($clog2(MAX_WIDTH + 1) > cpc_pkg::CFG_W) ?
                           $clog2(MAX_WIDTH + 1) : cpc_pkg::CFG_W;
    localparam int GH_W  = ($clog2(MAX_HEIGHT + 1) > cpc_pkg::CFG_W) ?
                           $clog2(MAX_HEIGHT + 1) : cpc_pkg::CFG_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [cpc_pkg::CFG_W-1:0]    width_reg;
    logic [cpc_pkg::CFG_W-1:0]    height_reg;
    logic [cpc_pkg::THRESH_W-1:0] thresh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= cpc_pkg::RESET_IMAGE_WIDTH;
            height_reg <= cpc_pkg::RESET_IMAGE_HEIGHT;
            thresh_reg <= cpc_pkg::RESET_CONTRAST_THRESHOLD;
        end else if (cfg_we) begin
            case (cfg_index)
                cpc_pkg::REG_IMAGE_WIDTH:        width_reg  <= cfg_wdata;
                cpc_pkg::REG_IMAGE_HEIGHT:       height_reg <= cfg_wdata;
                cpc_pkg::REG_CONTRAST_THRESHOLD: thresh_reg <= cfg_wdata[cpc_pkg::THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp geometry into 1..MAX and keep it as last index (size minus one).
    logic [GW_W-1:0]  width_ext;
    logic [GH_W-1:0]  height_ext;
    logic [COL_W-1:0] last_col_idx;
    logic [ROW_W-1:0] last_row_idx;

    assign width_ext  = GW_W'(width_reg);
    assign height_ext = GH_W'(height_reg);

    always_comb begin
        if (width_reg == '0) begin
            last_col_idx = '0;
        end else if (width_ext > GW_W'(MAX_WIDTH)) begin
            last_col_idx = COL_W'(MAX_WIDTH - 1);
        end else begin
            last_col_idx = COL_W'(width_ext - GW_W'(1));
        end
        if (height_reg == '0) begin
            last_row_idx = '0;
        end else if (height_ext > GH_W'(MAX_HEIGHT)) begin
            last_row_idx = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            last_row_idx = ROW_W'(height_ext - GH_W'(1));
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: accept a pixel, advance raster position, issue buffer reads
    // ------------------------------------------------------------------
    logic             s_accept;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             at_last_col;
    logic             at_last_row;

    assign s_accept    = s_tvalid && s_tready;
    assign at_last_col = (col_reg >= last_col_idx);
    assign at_last_row = (row_reg >= last_row_idx);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_accept) begin
            if (!at_last_col) begin
                col_next = col_reg + COL_W'(1);
            end else begin
                col_next = '0;
                row_next = at_last_row ? '0 : row_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line buffers: previous-row pixels and pending flags
    // ------------------------------------------------------------------
    logic                          pix_we;
    logic [COL_W-1:0]              pix_waddr;
    logic [cpc_pkg::PIXEL_W-1:0]   pix_wdata;
    logic [cpc_pkg::PIXEL_W-1:0]   pix_rdata;
    logic                          flag_we;
    logic [COL_W-1:0]              flag_waddr;
    logic                          flag_wdata;
    logic                          flag_rdata;

    cpc_ram #(
        .WIDTH (cpc_pkg::PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_pixel_line (
        .aclk  (aclk),
        .we    (pix_we),
        .waddr (pix_waddr),
        .wdata (pix_wdata),
        .re    (s_accept),
        .raddr (col_reg),
        .rdata (pix_rdata)
    );

    cpc_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WIDTH)
    ) u_flag_line (
        .aclk  (aclk),
        .we    (flag_we),
        .waddr (flag_waddr),
        .wdata (flag_wdata),
        .re    (s_accept),
        .raddr (col_reg),
        .rdata (flag_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1 registers
    // ------------------------------------------------------------------
    logic                        s1_valid_reg;
    logic [cpc_pkg::PIXEL_W-1:0] s1_pix_reg;
    logic [COL_W-1:0]            s1_col_reg;
    logic                        s1_has_up_reg;    // row above exists
    logic                        s1_last_col_reg;
    logic                        s1_last_row_reg;
    // forwarding of a write that lands in the same cycle as the read
    logic                        s1_pix_fwd_reg;
    logic [cpc_pkg::PIXEL_W-1:0] s1_pix_fwd_data_reg;
    logic                        s1_flag_fwd_reg;
    logic                        s1_flag_fwd_data_reg;

    logic                        s1_emit;
    logic                        s1_go;
    logic                        out_free;

    logic                        m_tvalid_reg;
    logic [cpc_pkg::COUNT_W-1:0] m_count_reg;

    assign s1_emit  = s1_last_col_reg && s1_last_row_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s1_go    = s1_valid_reg && (!s1_emit || out_free);
    assign s_tready = !s1_valid_reg || s1_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_go) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pix_reg           <= s_tdata[cpc_pkg::PIXEL_W-1:0];
            s1_col_reg           <= col_reg;
            s1_has_up_reg        <= (row_reg != '0);
            s1_last_col_reg      <= at_last_col;
            s1_last_row_reg      <= at_last_row;
            s1_pix_fwd_reg       <= pix_we && (pix_waddr == col_reg);
            s1_pix_fwd_data_reg  <= pix_wdata;
            s1_flag_fwd_reg      <= flag_we && (flag_waddr == col_reg);
            s1_flag_fwd_data_reg <= flag_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: compare with neighbours, finalise pixels, write back
    // ------------------------------------------------------------------
    logic [cpc_pkg::PIXEL_W-1:0] left_pixel_reg, left_pixel_next;
    logic                        cur_flag_reg, cur_flag_next;
    logic [cpc_pkg::COUNT_W-1:0] count_reg, count_next, count_sum;

    logic [cpc_pkg::PIXEL_W-1:0] up_pix;
    logic                        up_flag;
    logic                        has_left;
    logic                        up_c;
    logic                        left_c;
    logic                        left_flag;
    logic                        cur;
    logic                        inc_up;
    logic                        inc_left;
    logic                        inc_self;

    // deferred write of the last column's own flag
    logic                        defer_valid_reg;
    logic [COL_W-1:0]            defer_addr_reg;
    logic                        defer_data_reg;
    logic                        s1_flag_we;

    assign up_pix    = s1_pix_fwd_reg  ? s1_pix_fwd_data_reg  : pix_rdata;
    assign up_flag   = s1_flag_fwd_reg ? s1_flag_fwd_data_reg : flag_rdata;
    assign has_left  = (s1_col_reg != '0);
    assign up_c      = s1_has_up_reg && cpc_pkg::differs(s1_pix_reg, up_pix, thresh_reg);
    assign left_c    = has_left && cpc_pkg::differs(s1_pix_reg, left_pixel_reg, thresh_reg);
    assign left_flag = cur_flag_reg || left_c;
    assign cur       = up_c || left_c;

    // pixel above is final now; on the last row the left pixel is final now;
    // the frame's last pixel finalises itself
    assign inc_up    = s1_has_up_reg && (up_flag || up_c);
    assign inc_left  = has_left && s1_last_row_reg && left_flag;
    assign inc_self  = s1_emit && cur;

    assign count_sum = count_reg + cpc_pkg::COUNT_W'(inc_up)
                                 + cpc_pkg::COUNT_W'(inc_left)
                                 + cpc_pkg::COUNT_W'(inc_self);

    always_comb begin
        count_next      = count_reg;
        left_pixel_next = left_pixel_reg;
        cur_flag_next   = cur_flag_reg;
        if (s1_go) begin
            count_next      = s1_emit ? '0 : count_sum;
            left_pixel_next = s1_last_col_reg ? '0 : s1_pix_reg;
            cur_flag_next   = s1_last_col_reg ? 1'b0 : cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            left_pixel_reg <= '0;
            cur_flag_reg   <= 1'b0;
        end else begin
            count_reg      <= count_next;
            left_pixel_reg <= left_pixel_next;
            cur_flag_reg   <= cur_flag_next;
        end
    end

    // Pixel line: write this pixel back at its own column.
    assign pix_we    = s1_go;
    assign pix_waddr = s1_col_reg;
    assign pix_wdata = s1_pix_reg;

    // Flag line: the left neighbour's flag goes to column-1; at the end of a row
    // this pixel's flag also goes to its own column, in the next cycle if the port is busy.
    // The next row starts at column 0, which writes no flag, so the port is free then.
    assign s1_flag_we = s1_go && (has_left || s1_last_col_reg);

    always_comb begin
        if (defer_valid_reg) begin
            flag_we    = 1'b1;
            flag_waddr = defer_addr_reg;
            flag_wdata = defer_data_reg;
        end else begin
            flag_we    = s1_flag_we;
            flag_waddr = has_left ? s1_col_reg - COL_W'(1) : s1_col_reg;
            flag_wdata = has_left ? left_flag : cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            defer_valid_reg <= 1'b0;
        end else begin
            defer_valid_reg <= s1_go && has_left && s1_last_col_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go) begin
            defer_addr_reg <= s1_col_reg;
            defer_data_reg <= cur;
        end
    end

    // ------------------------------------------------------------------
    // Output register: hold the count until the transfer completes
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s1_go && s1_emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go && s1_emit) begin
            m_count_reg <= count_sum;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = cpc_pkg::M_TDATA_W'(m_count_reg);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // an empty update stage never refuses a pixel
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_valid_reg |-> s_tready)
        else $error("input refused with empty update stage");

    // the deferred flag write never meets a flag write from the update stage
    a_defer_no_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        defer_valid_reg |-> !(s1_go && has_left))
        else $error("flag line write port collision");

    // a count only appears after the frame's last pixel left the update stage
    a_emit_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(s1_go && s1_emit))
        else $error("count presented without a finished frame");

    // a stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !(s1_go && s1_emit))
        else $error("pending count overwritten");

endmodule

// ----- tb/contrast_count_tb_pkg.sv -----
// Scoreboard for the contrast pixel counter testbench: holds its own copy of
// the registers, line buffers and frame position, and the counts still due.
// Depends on cpc_pkg.
package contrast_count_tb_pkg;

    class contrast_count_scoreboard_t;
        logic [cpc_pkg::CFG_W-1:0]    width_reg;
        logic [cpc_pkg::CFG_W-1:0]    height_reg;
        logic [cpc_pkg::THRESH_W-1:0] thr_reg;

        logic [cpc_pkg::PIXEL_W-1:0]  row_above [cpc_pkg::DEFAULT_MAX_WIDTH];
        bit                           flag_above [cpc_pkg::DEFAULT_MAX_WIDTH];
        logic [cpc_pkg::PIXEL_W-1:0]  left_px;
        bit                           left_flag;
        int                           row;
        int                           col;
        logic [cpc_pkg::COUNT_W-1:0]  tally;

        logic [cpc_pkg::COUNT_W-1:0]  counts_due [$];
        int                           mismatches;

        function new();
            width_reg  = cpc_pkg::RESET_IMAGE_WIDTH;
            height_reg = cpc_pkg::RESET_IMAGE_HEIGHT;
            thr_reg    = cpc_pkg::RESET_CONTRAST_THRESHOLD;
            foreach (row_above[i]) begin
                row_above[i]  = '0;
                flag_above[i] = 1'b0;
            end
            left_px    = '0;
            left_flag  = 1'b0;
            row        = 0;
            col        = 0;
            tally      = '0;
            mismatches = 0;
        endfunction

        function void write_reg(input logic [cpc_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [cpc_pkg::CFG_W-1:0] val);
            case (idx)
                cpc_pkg::REG_IMAGE_WIDTH:        width_reg = val;
                cpc_pkg::REG_IMAGE_HEIGHT:       height_reg = val;
                cpc_pkg::REG_CONTRAST_THRESHOLD: thr_reg = val[cpc_pkg::THRESH_W-1:0];
                default: ;
            endcase
        endfunction

        // zero reads as one, anything past the buffer size as the maximum
        function int clamp_dim(input int v, input int maxv);
            if (v < 1) return 1;
            if (v > maxv) return maxv;
            return v;
        endfunction

        function int frame_pixels();
            return clamp_dim(width_reg, cpc_pkg::DEFAULT_MAX_WIDTH) *
                   clamp_dim(height_reg, cpc_pkg::DEFAULT_MAX_HEIGHT);
        endfunction

        function bit contrasts(input logic [cpc_pkg::PIXEL_W-1:0] a,
                               input logic [cpc_pkg::PIXEL_W-1:0] b);
            int d;
            d = (a > b) ? a - b : b - a;
            return d > thr_reg;
        endfunction

        function void note_pixel(input logic [cpc_pkg::PIXEL_W-1:0] px);
            int w;
            int h;
            bit last_col;
            bit last_row;
            bit up_c;
            bit left_c;
            bit lf;
            w        = clamp_dim(width_reg, cpc_pkg::DEFAULT_MAX_WIDTH);
            h        = clamp_dim(height_reg, cpc_pkg::DEFAULT_MAX_HEIGHT);
            last_col = (col >= w - 1);
            last_row = (row >= h - 1);
            up_c     = 1'b0;
            left_c   = 1'b0;
            // the pixel above is final once its lower neighbour is in
            if (row > 0) begin
                up_c = contrasts(px, row_above[col]);
                if (flag_above[col] | up_c) tally++;
            end
            if (col > 0) begin
                left_c = contrasts(px, left_px);
                lf = left_flag | left_c;
                flag_above[col-1] = lf;
                // bottom row: the left pixel is final once its right neighbour is in
                if (last_row && lf) tally++;
            end
            left_flag      = up_c | left_c;
            row_above[col] = px;
            left_px        = px;
            if (!last_col) begin
                col++;
                return;
            end
            flag_above[col] = left_flag;
            col       = 0;
            left_flag = 1'b0;
            left_px   = '0;
            if (!last_row) begin
                row++;
                return;
            end
            if (up_c | left_c) tally++;
            counts_due.push_back(tally);
            tally = '0;
            row   = 0;
        endfunction

        function void check_count(input logic [cpc_pkg::M_TDATA_W-1:0] data);
            logic [cpc_pkg::COUNT_W-1:0] got;
            logic [cpc_pkg::COUNT_W-1:0] want;
            got = data[cpc_pkg::COUNT_W-1:0];
            if (counts_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: count %0d arrived with no frame outstanding", got);
                return;
            end
            want = counts_due.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: count mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

endpackage

// ----- tb/tb_contrast_pixel_counter_top.sv -----
// Top-level testbench of the contrast pixel counter: streams frames of pixels
// under changing geometry, threshold and back-pressure and checks every count.
// Depends on cpc_pkg, contrast_count_tb_pkg and contrast_pixel_counter_top.
module tb_contrast_pixel_counter_top;
    timeunit 1ns;
    timeprecision 1ps;

    // kinds of pixel content for the random frames
    typedef enum int {
        PIX_UNIFORM,    // any value
        PIX_SMOOTH,     // small steps, mostly below the threshold
        PIX_BINARY,     // black and white only
        PIX_EDGE        // differences of exactly the threshold and one above
    } pixel_mix_t;

    localparam int RANDOM_PIXELS = 2000;

    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [cpc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [cpc_pkg::CFG_W-1:0]       cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [cpc_pkg::S_TDATA_W-1:0]   s_tdata   = '0;   // [7:0] pixel
    logic                            m_tvalid;
    logic                            m_tready  = 1'b1;
    logic [cpc_pkg::M_TDATA_W-1:0]   m_tdata;          // [18:0] contrast_count

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int pixels_sent    = 0;

    contrast_count_tb_pkg::contrast_count_scoreboard_t sb = new();

    contrast_pixel_counter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    // Receiver: stall at random according to the current phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: values read just after the edge are the ones the block saw.
    // Check the result first; a count can never stem from the pixel of the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_count(m_tdata);
            if (s_tvalid && s_tready) sb.note_pixel(s_tdata[cpc_pkg::PIXEL_W-1:0]);
        end
    end

    // Offer one pixel, idling beforehand as the phase asks, and hold it until
    // the transfer. Valid stays high between back-to-back pixels.
    task automatic send_pixel(input logic [cpc_pkg::PIXEL_W-1:0] px);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
    endtask

    task automatic send_list(input logic [cpc_pkg::PIXEL_W-1:0] pix [$]);
        foreach (pix[i]) send_pixel(pix[i]);
    endtask

    // Drop valid, wait for every count due, then allow for the two-stage pipeline.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.counts_due.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Write all three registers while the block is idle.
    task automatic load_regs(input logic [cpc_pkg::CFG_W-1:0] w,
                             input logic [cpc_pkg::CFG_W-1:0] h,
                             input logic [cpc_pkg::THRESH_W-1:0] thr);
        logic [cpc_pkg::CFG_W-1:0]       vals [3];
        logic [cpc_pkg::CFG_INDEX_W-1:0] idx  [3];
        settle();
        vals[0] = w;
        vals[1] = h;
        vals[2] = cpc_pkg::CFG_W'(thr);
        idx[0]  = cpc_pkg::REG_IMAGE_WIDTH;
        idx[1]  = cpc_pkg::REG_IMAGE_HEIGHT;
        idx[2]  = cpc_pkg::REG_CONTRAST_THRESHOLD;
        for (int i = 0; i < 3; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
            sb.write_reg(idx[i], vals[i]);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    // Send one whole frame of the current geometry with the given content.
    task automatic send_random_frame(input pixel_mix_t mix);
        logic [cpc_pkg::PIXEL_W-1:0] px;
        logic [cpc_pkg::PIXEL_W-1:0] base;
        int                          thr;
        int                          n;
        thr  = sb.thr_reg;
        base = cpc_pkg::PIXEL_W'($urandom_range(0, 255 - thr));
        px   = cpc_pkg::PIXEL_W'($urandom);
        n    = sb.frame_pixels();
        for (int k = 0; k < n; k++) begin
            case (mix)
                PIX_UNIFORM: px = cpc_pkg::PIXEL_W'($urandom);
                PIX_SMOOTH:  px = cpc_pkg::PIXEL_W'(int'(px) + int'($urandom_range(0, 6)) - 3);
                PIX_BINARY:  px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default: begin
                    case ($urandom_range(0, 2))
                        0:       px = base;
                        1:       px = cpc_pkg::PIXEL_W'(int'(base) + thr);
                        default: px = (int'(base) + thr >= 255) ?
                                      8'hFF : cpc_pkg::PIXEL_W'(int'(base) + thr + 1);
                    endcase
                end
            endcase
            send_pixel(px);
        end
    endtask

    initial begin
        logic [cpc_pkg::PIXEL_W-1:0]  seq [$];
        logic [cpc_pkg::CFG_W-1:0]    w;
        logic [cpc_pkg::CFG_W-1:0]    h;
        logic [cpc_pkg::THRESH_W-1:0] thr;
        int                           random_start;

        // Hold reset at the start, once only.
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed frames, no idling on either side.
        // A single-pixel image has no neighbours and counts nothing.
        load_regs(10'd1, 10'd1, 8'd128);
        send_pixel(8'hFF);
        // One row: only left/right neighbours, full-scale swings just above the threshold.
        load_regs(10'd4, 10'd1, 8'd254);
        seq = {8'd0, 8'd255, 8'd255, 8'd0};
        send_list(seq);
        // A zero width is treated as one column; zero threshold, equal pixels do not count.
        load_regs(10'd0, 10'd4, 8'd0);
        seq = {8'd7, 8'd7, 8'd8, 8'd8};
        send_list(seq);
        // The highest threshold can never be exceeded.
        load_regs(10'd3, 10'd3, 8'd255);
        seq = {8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0};
        send_list(seq);
        // Differences of exactly the threshold and one above it.
        load_regs(10'd3, 10'd3, 8'd127);
        seq = {8'd0, 8'd128, 8'd255, 8'd255, 8'd127, 8'd0, 8'd0, 8'd128, 8'd255};
        send_list(seq);

        // Random frames: mostly small, a few at the largest and clamped sizes.
        random_start = pixels_sent;
        for (int frame = 0; pixels_sent < random_start + RANDOM_PIXELS || frame < 30;
             frame++) begin
            case ((frame / 6) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase

            case ($urandom_range(0, 7))
                0:       thr = 8'd0;
                1:       thr = 8'd255;
                default: thr = cpc_pkg::THRESH_W'($urandom);
            endcase

            if (frame < 30 && frame % 10 == 5) begin
                case (frame / 10)
                    0:       begin w = 10'd1023; h = 10'd2;    end
                    1:       begin w = 10'd1;    h = 10'd1000; end
                    default: begin w = 10'd2;    h = 10'd100;  end
                endcase
            end else if ($urandom_range(0, 19) == 0) begin
                w = 10'd0;
                h = cpc_pkg::CFG_W'($urandom_range(1, 6));
            end else if ($urandom_range(0, 9) == 0) begin
                w = cpc_pkg::CFG_W'($urandom_range(9, 40));
                h = cpc_pkg::CFG_W'($urandom_range(1, 6));
            end else begin
                w = cpc_pkg::CFG_W'($urandom_range(1, 8));
                h = cpc_pkg::CFG_W'($urandom_range(1, 8));
            end

            load_regs(w, h, thr);
            send_random_frame(pixel_mix_t'($urandom_range(0, 3)));
        end

        // Drain: every count due must have arrived, then let the pipeline run dry.
        settle();
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.counts_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
